### src/strided_slice_address_generator_macros.svh
// Assertion macros shared by the strided slice address generator modules.
`ifndef STRIDED_SLICE_ADDRESS_GENERATOR_MACROS_SVH
`define STRIDED_SLICE_ADDRESS_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during rst.
`define SSAG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssag assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define SSAG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssag assertion failed");
`else
`define SSAG_ASSERT_NOW(label, ante, cons)
`define SSAG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/ssag_pkg.sv
// Types, codes and constants of the strided slice address generator.
package ssag_pkg;

  localparam int MAX_RANK_DEF = 8;
  localparam int RANK_W       = 4;

  // Request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_NEXT  = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_REJECT  = 2'd1;
  localparam logic [1:0] STS_NOT_RUN = 2'd2;

  // Datapath operations
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_BEGIN  = 3'd2;
  localparam logic [2:0] OP_STEP   = 3'd3;
  localparam logic [2:0] OP_FINISH = 3'd4;
  localparam logic [2:0] OP_NEXT   = 3'd5;
  localparam logic [2:0] OP_IGNORE = 3'd6;

  // Validation phases of one axis, one multiply each but for PH_FIRST
  localparam logic [2:0] PH_SLICE_MUL = 3'd0;
  localparam logic [2:0] PH_SLICE     = 3'd1;
  localparam logic [2:0] PH_INPROD    = 3'd2;
  localparam logic [2:0] PH_OUTPROD   = 3'd3;
  localparam logic [2:0] PH_DELTA     = 3'd4;
  localparam logic [2:0] PH_SPAN      = 3'd5;
  localparam logic [2:0] PH_FIRST     = 3'd6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  axis;
    logic [31:0] axis_in_size;
    logic [31:0] axis_out_size;
    logic [31:0] axis_start;
    logic [31:0] axis_step;
    logic [31:0] expected_count;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] source_index;
    logic [31:0] source_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [2:0]        phase;
    logic [RANK_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic              fail;
    logic              rank_bad;
    logic [RANK_W-1:0] rank;
  } stat_t;

endpackage

### src/ssag_controller.sv
// Sequencer: accepts transactions and steps the per-axis validation.
`include "strided_slice_address_generator_macros.svh"
module ssag_controller import ssag_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  stat_t      stat,
  output logic       busy,
  output logic       done,
  output cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_STEP   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]        state;
  logic [2:0]        phase;
  logic [RANK_W-1:0] axis;
  logic              accept;
  logic [RANK_W-1:0] rank_m1;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign rank_m1 = stat.rank - RANK_W'(1);

  // Command to the datapath
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.phase = phase;
    cmd.axis  = axis;
    if (accept) begin
      unique case (req_type)
        REQ_LOAD:  cmd.op = OP_LOAD;
        REQ_START: cmd.op = OP_BEGIN;
        REQ_NEXT:  cmd.op = OP_NEXT;
        default:   cmd.op = OP_IGNORE;
      endcase
    end else if (state == ST_STEP) begin
      cmd.op = OP_STEP;
    end else if (state == ST_FINISH) begin
      cmd.op = OP_FINISH;
    end
  end

  // State, axis and phase sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_SLICE_MUL;
      axis  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req_type != REQ_START || stat.rank_bad) begin
              done <= 1'b1;
            end else begin
              state <= ST_STEP;
              phase <= PH_SLICE_MUL;
              axis  <= rank_m1;
            end
          end
        end
        ST_STEP: begin
          if (stat.fail) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else if (phase == PH_FIRST) begin
            phase <= PH_SLICE_MUL;
            if (axis == '0) state <= ST_FINISH;
            else axis <= axis - RANK_W'(1);
          end else begin
            phase <= phase + 3'd1;
          end
        end
        ST_FINISH: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SSAG_ASSERT_NEXT(a_last_axis_finishes,
    state == ST_STEP && phase == PH_FIRST && axis == '0 && !stat.fail, state == ST_FINISH)
  `SSAG_ASSERT_NEXT(a_next_answers_at_once, accept && req_type == REQ_NEXT, done && !busy)

endmodule

### src/ssag_datapath.sv
// Descriptor tables, shared multiplier, validation checks and index odometer.
`include "strided_slice_address_generator_macros.svh"
module ssag_datapath import ssag_pkg::*; #(
  parameter int MAX_RANK = MAX_RANK_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  in_t               req,
  input  logic              cfg_wr_en,
  input  logic [RANK_W-1:0] cfg_wr_data,
  output stat_t             stat,
  output out_t              result
);

  localparam int AW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

  logic [31:0] in_size_tab  [MAX_RANK];
  logic [31:0] out_size_tab [MAX_RANK];
  logic [31:0] start_tab    [MAX_RANK];
  logic [31:0] step_tab     [MAX_RANK];
  logic [31:0] carry_tab    [MAX_RANK];
  logic [31:0] cnt          [MAX_RANK];

  logic [RANK_W-1:0] rank;
  logic [63:0] prod;
  logic [31:0] in_prod, out_prod, first, acc, new_in_prod, expected;
  logic [31:0] current, remaining;
  logic        running;

  logic [AW-1:0] a;
  logic [31:0]   isz, osz, st, sp;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;
  logic          slice_bad, fail, rank_bad, count_ok, ld_ok;
  logic [AW+2:0] ld_ext;
  logic [AW-1:0] ld_idx;
  logic [AW-1:0] k;
  logic [MAX_RANK-1:0] wrap;

  assign a   = cmd.axis[AW-1:0];
  assign isz = in_size_tab[a];
  assign osz = out_size_tab[a];
  assign st  = start_tab[a];
  assign sp  = step_tab[a];

  assign rank_bad = (rank == '0) || ({28'd0, rank} > 32'(MAX_RANK));
  assign ld_ext   = {{AW{1'b0}}, req.axis};
  assign ld_idx   = ld_ext[AW-1:0];
  assign ld_ok    = ({29'd0, req.axis} < 32'(MAX_RANK));
  assign count_ok = (out_prod == expected);

  // Shared multiplier operands per phase
  always_comb begin
    unique case (cmd.phase)
      PH_SLICE_MUL: begin mul_a = osz - 32'd1; mul_b = sp;          end
      PH_SLICE:     begin mul_a = in_prod;     mul_b = isz;         end
      PH_INPROD:    begin mul_a = out_prod;    mul_b = osz;         end
      PH_OUTPROD:   begin mul_a = sp;          mul_b = in_prod;     end
      PH_DELTA:     begin mul_a = osz - 32'd1; mul_b = prod[31:0];  end
      PH_SPAN:      begin mul_a = st;          mul_b = in_prod;     end
      default:      begin mul_a = '0;          mul_b = '0;          end
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // Axis checks: (osz-1)*step must stay below isz-start; products fit 32 bits
  assign slice_bad = (isz == '0) || (osz == '0) || (sp == '0) || (st >= isz) ||
                     (prod >= {32'd0, isz - st});
  always_comb begin
    fail = 1'b0;
    if (cmd.op == OP_STEP) begin
      unique case (cmd.phase)
        PH_SLICE:   fail = slice_bad;
        PH_INPROD:  fail = (prod[63:32] != '0);
        PH_OUTPROD: fail = (prod[63:32] != '0);
        default:    fail = 1'b0;
      endcase
    end
  end

  assign stat.fail     = fail;
  assign stat.rank_bad = rank_bad;
  assign stat.rank     = rank;

  // Odometer: innermost axis not at its last coordinate takes the carry
  always_comb begin
    k = '0;
    for (int i = 0; i < MAX_RANK; i++) begin
      if (i < int'(rank) && cnt[i] != out_size_tab[i] - 32'd1) k = AW'(i);
    end
    for (int i = 0; i < MAX_RANK; i++) begin
      wrap[i] = (i > int'(k));
    end
  end

  // Validation accumulators
  always_ff @(posedge clk) begin
    if (cmd.op == OP_BEGIN) begin
      in_prod  <= 32'd1;
      out_prod <= 32'd1;
      first    <= '0;
      acc      <= '0;
      expected <= req.expected_count;
    end else if (cmd.op == OP_STEP) begin
      prod <= mul_p;
      unique case (cmd.phase)
        PH_INPROD:  new_in_prod <= prod[31:0];
        PH_OUTPROD: out_prod    <= prod[31:0];
        PH_DELTA:   carry_tab[a] <= prod[31:0] - acc;
        PH_SPAN:    acc         <= acc + prod[31:0];
        PH_FIRST: begin
          first   <= first + prod[31:0];
          in_prod <= new_in_prod;
        end
        default: ;
      endcase
    end
  end

  // Descriptor tables
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && ld_ok) begin
      in_size_tab[ld_idx]  <= req.axis_in_size;
      out_size_tab[ld_idx] <= req.axis_out_size;
      start_tab[ld_idx]    <= req.axis_start;
      step_tab[ld_idx]     <= req.axis_step;
    end
  end

  // Coordinate counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_RANK; i++) cnt[i] <= '0;
    end else if (cmd.op == OP_FINISH) begin
      for (int i = 0; i < MAX_RANK; i++) cnt[i] <= '0;
    end else if (cmd.op == OP_NEXT && running && remaining > 32'd1) begin
      for (int i = 0; i < MAX_RANK; i++) begin
        if (i == int'(k)) cnt[i] <= cnt[i] + 32'd1;
        else if (wrap[i]) cnt[i] <= '0;
      end
    end
  end

  // Rank, walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      rank      <= RANK_W'(1);
      running   <= 1'b0;
      current   <= '0;
      remaining <= '0;
    end else begin
      if (cfg_wr_en) begin
        rank    <= cfg_wr_data;
        running <= 1'b0;
      end
      unique case (cmd.op)
        OP_LOAD:  if (ld_ok) running <= 1'b0;
        OP_BEGIN: if (rank_bad) running <= 1'b0;
        OP_STEP:  if (fail) running <= 1'b0;
        OP_FINISH: begin
          running <= count_ok;
          if (count_ok) begin
            current   <= first;
            remaining <= out_prod;
          end
        end
        OP_NEXT: begin
          if (running) begin
            if (remaining <= 32'd1) begin
              remaining <= '0;
              running   <= 1'b0;
            end else begin
              remaining <= remaining - 32'd1;
              current   <= current + carry_tab[k];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD, OP_IGNORE: result <= '0;
      OP_BEGIN: if (rank_bad) result <= '{STS_REJECT, 32'd0, 32'd0, 1'b0};
      OP_STEP:  if (fail) result <= '{STS_REJECT, 32'd0, 32'd0, 1'b0};
      OP_FINISH: begin
        if (count_ok) result <= '{STS_OK, 32'd0, in_prod, 1'b0};
        else result <= '{STS_REJECT, 32'd0, 32'd0, 1'b0};
      end
      OP_NEXT: begin
        if (running) result <= '{STS_OK, current, 32'd0, remaining <= 32'd1};
        else result <= '{STS_NOT_RUN, 32'd0, 32'd0, 1'b0};
      end
      default: ;
    endcase
  end

  `SSAG_ASSERT_NEXT(a_last_stops_walk,
    cmd.op == OP_NEXT && running && remaining <= 32'd1, !running && remaining == '0)
  `SSAG_ASSERT_NEXT(a_reject_clears_running, fail, !running)

endmodule

### src/strided_slice_address_generator.sv
// Strided slice address generator: top level joining sequencer and datapath.
//
// Command channel: a transaction is taken when start is high and busy is low;
// req carries the request type and its fields. Each transaction gives exactly
// one result on result, marked by done for a single cycle; the receiver takes
// it at that edge and cannot hold it off.
// Load, next and unused requests answer one cycle after acceptance, and busy
// stays low, so next requests stream at one index per cycle from an odometer
// whose per-axis carry deltas are precomputed at start.
// A start walks the axes from innermost to outermost, phase by phase per axis
// through one shared 32x32 multiplier, then makes the count compare; busy stays
// high until the result is given. A bad rank answers at once, a rejected axis
// ends the walk early.
// Write the rank register via cfg_wr_en/cfg_wr_data only while idle; the block
// does not enforce it. A write or a valid-axis load aborts a running walk.
// Reset (synchronous, active high) sets rank to 1 and clears the walk; the
// descriptor tables hold nothing until loaded.
module strided_slice_address_generator import ssag_pkg::*; #(
  parameter int MAX_RANK = MAX_RANK_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_t               req,
  output logic              done,
  output out_t              result,
  input  logic              cfg_wr_en,
  input  logic [RANK_W-1:0] cfg_wr_data
);

  cmd_t  cmd;
  stat_t stat;

  ssag_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .stat     (stat),
    .busy     (busy),
    .done     (done),
    .cmd      (cmd)
  );

  ssag_datapath #(.MAX_RANK(MAX_RANK)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req         (req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .result      (result)
  );

endmodule
